FILE: sv/dmd_pkg.sv
// Shared types and constants for the debounced motion detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package dmd_pkg;

    localparam int unsigned AXIS_W   = 16;
    localparam int unsigned DELTA_W  = 18;
    localparam int unsigned THRESH_W = 18;
    localparam int unsigned RUN_W    = 8;
    localparam int unsigned CFG_W    = 18;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [RUN_W-1:0]    RUN_MAX          = 8'd255;
    localparam logic [THRESH_W-1:0] THRESH_RESET     = 18'd1000;
    localparam logic [RUN_W-1:0]    DEBOUNCE_RESET   = 8'd3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTION_THRESHOLD = 1'b0,
        CFG_DEBOUNCE_COUNT   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic                     sample_valid;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_x;
    } sample_t;

    typedef struct packed {
        logic [DELTA_W-1:0] motion_delta;
        logic               motion_changed;
        logic               sensor_ok;
        logic               moving;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/debounced_motion_detector.sv
// Top level of the debounced motion detector: stream ports, config registers,
// input and result registers. Depends on dmd_pkg, dmd_track and dmd_delta.
`default_nettype none

// Each input beat carries one three-axis accelerometer sample plus a sensor
// valid flag; each beat produces exactly one result beat with the debounced
// moving flag, the sensor status, a change marker and the summed absolute
// axis difference against the previous sample. The block accepts one beat
// per clock while the sink takes results: a beat is captured in
// the input register, the difference sum, threshold compare and run counter
// update run combinationally from it into the result register, which holds the beat
// until the sink takes it. A full result register that the sink does not
// take holds the input register; with both registers full, s_axis_tready
// follows m_axis_tready combinationally.
// The first valid sample after reset or after a sensor fault only primes the
// detector and reports not moving with a zero difference. Configuration
// writes (threshold, debounce count) take effect at once and must be issued
// only while no beat is in flight.

module debounced_motion_detector
    import dmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // sample stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [47:0]          s_axis_tdata,  // accel_x, accel_y, accel_z
    input  wire logic                 s_axis_tuser,  // sample_valid
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [23:0]               m_axis_tdata,  // moving, motion_changed,
                                                     // motion_delta, zero pad
    output logic                      m_axis_tuser,  // sensor_ok
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [THRESH_W-1:0] threshold_reg;
    logic [RUN_W-1:0]    debounce_reg;
    logic                in_valid_reg;
    sample_t             in_sample_reg;
    logic                out_valid_reg;
    result_t             out_result_reg;
    result_t             step_result;
    logic                advance;
    logic                step;

    // Advance the pipeline whenever the result register is free or drains.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            debounce_reg  <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MOTION_THRESHOLD: threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_DEBOUNCE_COUNT:   debounce_reg  <= cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers: capture on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_sample_reg.accel_x      <= s_axis_tdata[15:0];
            in_sample_reg.accel_y      <= s_axis_tdata[31:16];
            in_sample_reg.accel_z      <= s_axis_tdata[47:32];
            in_sample_reg.sample_valid <= s_axis_tuser;
        end
        if (step)
        begin
            out_result_reg <= step_result;
        end
    end

    dmd_track u_track (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .sample           (in_sample_reg),
        .motion_threshold (threshold_reg),
        .debounce_count   (debounce_reg),
        .result           (step_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_result_reg.motion_delta,
                            out_result_reg.motion_changed, out_result_reg.moving};
    assign m_axis_tuser  = out_result_reg.sensor_ok;

endmodule

`default_nettype wire

FILE: sv/dmd_delta.sv
// Motion measure: sum of absolute differences over the three axes.
// Depends on dmd_pkg.
`default_nettype none

module dmd_delta
    import dmd_pkg::*;
(
    input  wire sample_t                  sample,
    input  wire logic signed [AXIS_W-1:0] last_x,
    input  wire logic signed [AXIS_W-1:0] last_y,
    input  wire logic signed [AXIS_W-1:0] last_z,
    output logic [DELTA_W-1:0]            delta
);

    logic signed [AXIS_W:0] dx;
    logic signed [AXIS_W:0] dy;
    logic signed [AXIS_W:0] dz;
    logic [AXIS_W-1:0]      ax;
    logic [AXIS_W-1:0]      ay;
    logic [AXIS_W-1:0]      az;

    always_comb
    begin
        dx = {sample.accel_x[AXIS_W-1], sample.accel_x} - {last_x[AXIS_W-1], last_x};
        dy = {sample.accel_y[AXIS_W-1], sample.accel_y} - {last_y[AXIS_W-1], last_y};
        dz = {sample.accel_z[AXIS_W-1], sample.accel_z} - {last_z[AXIS_W-1], last_z};
        // magnitude of a 17-bit difference always fits in 16 bits
        ax = dx[AXIS_W] ? AXIS_W'(-dx) : dx[AXIS_W-1:0];
        ay = dy[AXIS_W] ? AXIS_W'(-dy) : dy[AXIS_W-1:0];
        az = dz[AXIS_W] ? AXIS_W'(-dz) : dz[AXIS_W-1:0];
        delta = DELTA_W'(ax) + DELTA_W'(ay) + DELTA_W'(az);
    end

endmodule

`default_nettype wire

FILE: sv/dmd_track.sv
// Detector state: previous sample, priming, run counters and moving flag.
// Depends on dmd_pkg and dmd_delta.
`default_nettype none

module dmd_track
    import dmd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire sample_t             sample,
    input  wire logic [THRESH_W-1:0] motion_threshold,
    input  wire logic [RUN_W-1:0]    debounce_count,
    output result_t                  result
);

    logic signed [AXIS_W-1:0] last_x_reg, last_x_next;
    logic signed [AXIS_W-1:0] last_y_reg, last_y_next;
    logic signed [AXIS_W-1:0] last_z_reg, last_z_next;
    logic                     primed_reg, primed_next;
    logic                     moving_reg, moving_next;
    logic [RUN_W-1:0]         above_reg, above_next;
    logic [RUN_W-1:0]         below_reg, below_next;
    logic [DELTA_W-1:0]       delta;
    logic                     is_motion;

    dmd_delta u_delta (
        .sample (sample),
        .last_x (last_x_reg),
        .last_y (last_y_reg),
        .last_z (last_z_reg),
        .delta  (delta)
    );

    assign is_motion = delta >= motion_threshold;

    always_comb
    begin
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        last_z_next = last_z_reg;
        primed_next = primed_reg;
        moving_next = moving_reg;
        above_next  = above_reg;
        below_next  = below_reg;
        result.motion_delta = '0;
        if (!sample.sample_valid)
        begin
            last_x_next = '0;
            last_y_next = '0;
            last_z_next = '0;
            primed_next = 1'b0;
            moving_next = 1'b0;
            above_next  = '0;
            below_next  = '0;
        end
        else if (!primed_reg)
        begin
            last_x_next = sample.accel_x;
            last_y_next = sample.accel_y;
            last_z_next = sample.accel_z;
            primed_next = 1'b1;
            moving_next = 1'b0;
            above_next  = '0;
            below_next  = '0;
        end
        else
        begin
            result.motion_delta = delta;
            last_x_next = sample.accel_x;
            last_y_next = sample.accel_y;
            last_z_next = sample.accel_z;
            if (is_motion)
            begin
                above_next = (above_reg == RUN_MAX) ? above_reg : above_reg + 1'b1;
                below_next = '0;
            end
            else
            begin
                below_next = (below_reg == RUN_MAX) ? below_reg : below_reg + 1'b1;
                above_next = '0;
            end
            // below check last: it wins when the debounce count is zero
            if (above_next >= debounce_count)
            begin
                moving_next = 1'b1;
            end
            if (below_next >= debounce_count)
            begin
                moving_next = 1'b0;
            end
        end
        result.moving         = moving_next;
        result.sensor_ok      = sample.sample_valid;
        result.motion_changed = moving_next != moving_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
            last_z_reg <= '0;
            primed_reg <= 1'b0;
            moving_reg <= 1'b0;
            above_reg  <= '0;
            below_reg  <= '0;
        end
        else if (step)
        begin
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            last_z_reg <= last_z_next;
            primed_reg <= primed_next;
            moving_reg <= moving_next;
            above_reg  <= above_next;
            below_reg  <= below_next;
        end
    end

    a_moving_needs_primed: assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> primed_reg)
        else $error("moving flag set without a previous sample");

    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((above_reg != '0) && (below_reg != '0)))
        else $error("above and below runs both nonzero");

    a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !sample.sample_valid) |=> (!primed_reg && !moving_reg
            && (above_reg == '0) && (below_reg == '0)))
        else $error("invalid sample did not clear detector state");

    a_changed_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (moving_reg != $past(moving_reg)) == $past(result.motion_changed))
        else $error("motion_changed disagrees with moving flag update");

endmodule

`default_nettype wire

FILE: test/tb_debounced_motion_detector.sv
// Testbench for debounced_motion_detector: directed and random sample streams
// checked beat by beat against a behavioral tracker kept in this file.
// Depends on dmd_pkg and the debounced_motion_detector RTL.
`timescale 1ns / 100ps

module tb_debounced_motion_detector
    import dmd_pkg::*;
();

    localparam logic signed [AXIS_W-1:0] AXIS_MIN = 16'sh8000;
    localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sh7FFF;
    // Largest possible summed difference and the all-ones threshold above it
    localparam logic [THRESH_W-1:0] DELTA_PEAK = 18'd196605;
    localparam logic [THRESH_W-1:0] THRESH_ALL = 18'h3FFFF;
    localparam int SETTLE_CYCLES = 4;    // result path is two stages deep
    localparam int IDLE_PCT      = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;   // accel_x, accel_y, accel_z
    logic                 s_axis_tuser = 1'b0; // sample_valid
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;        // moving, motion_changed,
                                               // motion_delta, zero pad
    logic                 m_axis_tuser;        // sensor_ok
    logic                 cfg_we = 1'b0;
    cfg_idx_t             cfg_index = CFG_MOTION_THRESHOLD;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Tracker copy of the detector state and its registers
    logic [THRESH_W-1:0]      model_thresh;
    logic [RUN_W-1:0]         model_debounce;
    logic signed [AXIS_W-1:0] model_last_x, model_last_y, model_last_z;
    logic                     model_primed;
    logic                     model_moving;
    logic [RUN_W-1:0]         model_above, model_below;

    // Last valid sample sent; random motion walks away from it
    logic signed [AXIS_W-1:0] walk_x = '0, walk_y = '0, walk_z = '0;

    result_t motion_reports[$];
    int      mismatch_count = 0;
    bit      line_idles = 1'b1;

    debounced_motion_detector u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the handshake locks up
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Tracker
    // ---------------------------------------------------------------------

    function automatic int unsigned axis_gap(input logic signed [AXIS_W-1:0] a,
                                             input logic signed [AXIS_W-1:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic void clear_tracker();
        model_last_x = '0;
        model_last_y = '0;
        model_last_z = '0;
        model_primed = 1'b0;
        model_moving = 1'b0;
        model_above  = '0;
        model_below  = '0;
    endfunction

    // Advance the tracker by one sample and return the report it must produce
    function automatic result_t track_motion(input logic signed [AXIS_W-1:0] x,
                                             input logic signed [AXIS_W-1:0] y,
                                             input logic signed [AXIS_W-1:0] z,
                                             input logic ok);
        result_t     r;
        logic        was_moving;
        int unsigned sum;
        was_moving = model_moving;
        sum = 0;
        if (!ok)
        begin
            // sensor fault drops everything back to the reset state
            clear_tracker();
        end
        else if (!model_primed)
        begin
            // first good sample only sets the reference point
            model_last_x = x;
            model_last_y = y;
            model_last_z = z;
            model_primed = 1'b1;
            model_moving = 1'b0;
            model_above  = '0;
            model_below  = '0;
        end
        else
        begin
            sum = axis_gap(x, model_last_x) + axis_gap(y, model_last_y)
                + axis_gap(z, model_last_z);
            model_last_x = x;
            model_last_y = y;
            model_last_z = z;
            if (sum >= model_thresh)
            begin
                if (model_above < RUN_MAX)
                    model_above = model_above + 1'b1;
                model_below = '0;
            end
            else
            begin
                if (model_below < RUN_MAX)
                    model_below = model_below + 1'b1;
                model_above = '0;
            end
            // above is applied first, so a zero debounce always ends not moving
            if (model_above >= model_debounce)
                model_moving = 1'b1;
            if (model_below >= model_debounce)
                model_moving = 1'b0;
        end
        r.moving         = model_moving;
        r.sensor_ok      = ok;
        r.motion_changed = (model_moving != was_moving);
        r.motion_delta   = sum[DELTA_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Sink side: random back-pressure and beat checking
    // ---------------------------------------------------------------------

    always @(negedge clk)
        m_axis_tready <= !(line_idles && ($urandom_range(99) < IDLE_PCT));

    always @(posedge clk)
    begin : check_results
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.moving         = m_axis_tdata[0];
            got.motion_changed = m_axis_tdata[1];
            got.motion_delta   = m_axis_tdata[DELTA_W+1:2];
            got.sensor_ok      = m_axis_tuser;
            if (motion_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat moving=%0b ok=%0b chg=%0b delta=%0d",
                             $realtime, got.moving, got.sensor_ok, got.motion_changed,
                             got.motion_delta);
            end
            else
            begin
                want = motion_reports.pop_front();
                if (got.moving !== want.moving || got.sensor_ok !== want.sensor_ok ||
                    got.motion_changed !== want.motion_changed ||
                    got.motion_delta !== want.motion_delta)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch exp m=%0b ok=%0b chg=%0b d=%0d,",
                                  " got m=%0b ok=%0b chg=%0b d=%0d"},
                                 $realtime, want.moving, want.sensor_ok,
                                 want.motion_changed, want.motion_delta,
                                 got.moving, got.sensor_ok, got.motion_changed,
                                 got.motion_delta);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Source side helpers
    // ---------------------------------------------------------------------

    // Drive one sample beat, hold it until accepted, then predict its report
    task automatic send_sample(input logic signed [AXIS_W-1:0] x,
                               input logic signed [AXIS_W-1:0] y,
                               input logic signed [AXIS_W-1:0] z,
                               input logic ok);
        @(negedge clk);
        while (line_idles && ($urandom_range(99) < IDLE_PCT))
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= ok;
        do
            @(posedge clk);
        while (!s_axis_tready);
        motion_reports.push_back(track_motion(x, y, z, ok));
        if (ok)
        begin
            walk_x = x;
            walk_y = y;
            walk_z = z;
        end
    endtask

    // Drop valid and hold until every predicted report has come back
    task automatic wait_reports_done();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (motion_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; call only with the pipeline drained
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_MOTION_THRESHOLD: model_thresh   = value[THRESH_W-1:0];
            CFG_DEBOUNCE_COUNT:   model_debounce = value[RUN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Step one axis by a random amount in [lo, hi], folding back inside range
    function automatic logic signed [AXIS_W-1:0] nudge_axis(
            input logic signed [AXIS_W-1:0] base, input int unsigned lo,
            input int unsigned hi);
        int mag;
        int v;
        mag = $urandom_range(hi, lo);
        v = $urandom_range(1) ? int'(base) + mag : int'(base) - mag;
        if (v > 32767 || v < -32768)
            v = (v > 32767) ? int'(base) - mag : int'(base) + mag;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[AXIS_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset register values: priming, full-scale swings, the exact threshold,
    // a fault while moving and while still, re-priming after a fault
    task automatic test_default_debounce();
        send_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN, 1'b1);
        send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b1);
        send_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN, 1'b1);
        send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b1);
        send_sample(AXIS_MAX - 16'sd999, AXIS_MAX, AXIS_MAX, 1'b1);
        send_sample(AXIS_MAX - 16'sd999, AXIS_MAX - 16'sd1000, AXIS_MAX, 1'b1);
        send_sample(AXIS_MAX, -16'sd1, 16'sh5555, 1'b0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd1, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd1, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd1, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_sample(16'shAAAA, AXIS_MIN, AXIS_MAX, 1'b0);
        wait_reports_done();
    endtask

    // Threshold at the largest reachable sum, above range, and zero
    task automatic test_threshold_edges();
        write_reg(CFG_MOTION_THRESHOLD, DELTA_PEAK);
        write_reg(CFG_DEBOUNCE_COUNT, 18'd1);
        send_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN, 1'b1);
        send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b1);
        wait_reports_done();
        write_reg(CFG_MOTION_THRESHOLD, THRESH_ALL);
        send_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN, 1'b1);
        send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b1);
        wait_reports_done();
        write_reg(CFG_MOTION_THRESHOLD, 18'd0);
        send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b1);
        wait_reports_done();
    endtask

    // Zero debounce pins moving low while the above run climbs to its 255 limit;
    // raising the debounce to 255 then only sets moving if the run saturated
    task automatic test_run_saturation();
        int n;
        write_reg(CFG_DEBOUNCE_COUNT, 18'd0);
        for (n = 0; n < 270; n++)
            send_sample(AXIS_W'($urandom()), AXIS_W'($urandom()), AXIS_W'($urandom()),
                        1'b1);
        wait_reports_done();
        write_reg(CFG_DEBOUNCE_COUNT, 18'd255);
        send_sample(AXIS_W'($urandom()), AXIS_W'($urandom()), AXIS_W'($urandom()), 1'b1);
        wait_reports_done();
    endtask

    // Phases of motion and stillness bursts sized around the debounce count,
    // with some noise and sensor faults mixed in
    task automatic test_random_traffic();
        int          phase;
        int          n;
        int          roll;
        int          burst_left;
        int          run_cap;
        bit          burst_moves;
        int unsigned lo;
        int unsigned hi;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_MOTION_THRESHOLD, CFG_W'($urandom_range(3000, 200)));
                    write_reg(CFG_DEBOUNCE_COUNT, 18'd3);
                end
                1:
                begin
                    write_reg(CFG_MOTION_THRESHOLD, 18'd0);
                    write_reg(CFG_DEBOUNCE_COUNT, 18'd1);
                end
                2:
                begin
                    write_reg(CFG_MOTION_THRESHOLD, THRESH_ALL);
                    write_reg(CFG_DEBOUNCE_COUNT, 18'd2);
                end
                3:
                begin
                    write_reg(CFG_MOTION_THRESHOLD, DELTA_PEAK);
                    write_reg(CFG_DEBOUNCE_COUNT, 18'd1);
                end
                4:
                begin
                    write_reg(CFG_MOTION_THRESHOLD, CFG_W'($urandom_range(20000, 1)));
                    write_reg(CFG_DEBOUNCE_COUNT, 18'd0);
                end
                default:
                begin
                    write_reg(CFG_MOTION_THRESHOLD, CFG_W'($urandom_range(20000, 1)));
                    write_reg(CFG_DEBOUNCE_COUNT, CFG_W'($urandom_range(6, 1)));
                end
            endcase
            // one whole phase runs with both sides streaming flat out
            line_idles = (phase != 5);
            run_cap = (int'(model_debounce) + 2 > 40) ? 40 : int'(model_debounce) + 2;
            burst_left = 0;
            burst_moves = 1'b0;
            for (n = 0; n < 100; n++)
            begin
                // hold the sender once until the pipeline is empty
                if (phase == 2 && n == 50)
                    wait_reports_done();
                roll = $urandom_range(99);
                if (roll < 3)
                begin
                    send_sample(AXIS_W'($urandom()), AXIS_W'($urandom()),
                                AXIS_W'($urandom()), 1'b0);
                end
                else if (roll < 7)
                begin
                    send_sample(AXIS_W'($urandom()), AXIS_W'($urandom()),
                                AXIS_W'($urandom()), 1'b1);
                end
                else
                begin
                    if (burst_left == 0)
                    begin
                        burst_moves = !burst_moves;
                        burst_left = $urandom_range(run_cap, 1);
                    end
                    burst_left--;
                    if (burst_moves)
                    begin
                        lo = model_thresh / 3 + 1;
                        if (lo > 65535)
                            lo = 65535;
                        hi = lo + model_thresh / 2 + 500;
                        if (hi > 65535)
                            hi = 65535;
                    end
                    else
                    begin
                        lo = 0;
                        hi = model_thresh / 4;
                        if (hi > 65535)
                            hi = 65535;
                    end
                    send_sample(nudge_axis(walk_x, lo, hi), nudge_axis(walk_y, lo, hi),
                                nudge_axis(walk_z, lo, hi), 1'b1);
                end
            end
            wait_reports_done();
        end
        line_idles = 1'b1;
    endtask

    initial
    begin
        model_thresh   = THRESH_RESET;
        model_debounce = DEBOUNCE_RESET;
        clear_tracker();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_debounce();
        test_threshold_edges();
        test_run_saturation();
        test_random_traffic();

        wait_reports_done();
        if (mismatch_count == 0 && motion_reports.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
